@@ hw/rtl/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants of the JSON string unescaper
// Scan phase codes, result item layout, result group and small helpers for
// hex digit decoding and UTF-8 encoding.
// ----------------------------------------------------------------------------
package jsu_pkg;

    typedef enum logic [5:0] {
        PH_TEXT        = 6'b000001,
        PH_ESC         = 6'b000010,
        PH_HEX         = 6'b000100,
        PH_AFTER_HI    = 6'b001000,
        PH_AFTER_HI_BS = 6'b010000,
        PH_LOW_HEX     = 6'b100000
    } phase_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_UNI   = 2'd1;
    localparam logic [1:0] ST_BAD_PAIR  = 2'd2;
    localparam logic [1:0] ST_UNTERM    = 2'd3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [15:0] HI_SURR_MIN = 16'hD800;
    localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
    localparam logic [20:0] LO_SURR_BASE = 21'h00DC00;
    localparam logic [20:0] SUPP_BASE    = 21'h010000;

    localparam int unsigned GRP_DEPTH = 4;

    typedef struct packed {
        logic [1:0] status;
        logic       done_res;
        logic       has_byte;
        logic [7:0] out_byte;
    } res_t;

    // up to four result items caused by one input item
    typedef struct packed {
        res_t [GRP_DEPTH-1:0] res;
        logic [2:0]           n;
    } grp_t;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd0;
        if (c inside {[8'h30:8'h39]})
            d = {1'b1, c[3:0]};
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
            d = {1'b1, c[3:0] + 4'd9};
        return d;
    endfunction

    function automatic grp_t grp_push(input grp_t g, input res_t r);
        grp_t o;
        o = g;
        o.res[g.n[1:0]] = r;
        o.n = g.n + 3'd1;
        return o;
    endfunction

    function automatic grp_t grp_byte(input grp_t g, input logic [7:0] b);
        res_t r;
        r = '0;
        r.out_byte = b;
        r.has_byte = 1'b1;
        return grp_push(g, r);
    endfunction

    function automatic grp_t grp_done(input grp_t g, input logic [1:0] st);
        res_t r;
        r = '0;
        r.done_res = 1'b1;
        r.status   = st;
        return grp_push(g, r);
    endfunction

    function automatic grp_t grp_utf8(input grp_t g, input logic [20:0] cp);
        grp_t o;
        o = g;
        if (cp < 21'h80) begin
            o = grp_byte(o, cp[7:0]);
        end
        else if (cp < 21'h800) begin
            o = grp_byte(o, {3'b110, cp[10:6]});
            o = grp_byte(o, {2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000) begin
            o = grp_byte(o, {4'b1110, cp[15:12]});
            o = grp_byte(o, {2'b10, cp[11:6]});
            o = grp_byte(o, {2'b10, cp[5:0]});
        end
        else begin
            o = grp_byte(o, {5'b11110, cp[20:18]});
            o = grp_byte(o, {2'b10, cp[17:12]});
            o = grp_byte(o, {2'b10, cp[11:6]});
            o = grp_byte(o, {2'b10, cp[5:0]});
        end
        return o;
    endfunction

endpackage

@@ hw/rtl/jsu_decode.sv @@
// ----------------------------------------------------------------------------
// jsu_decode: scan state and item decoder
// Turns one registered input item into a group of result items and steps the
// scan state when the item moves on.
// ----------------------------------------------------------------------------
module jsu_decode
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           mode,
    input  logic [7:0]     in_byte,
    input  logic           advance,
    output jsu_pkg::grp_t  grp
);

    jsu_pkg::phase_t phase_reg, phase_next;
    logic [1:0]      hex_count_reg, hex_count_next;
    logic [15:0]     hex_value_reg, hex_value_next;
    logic [15:0]     high_half_reg, high_half_next;

    always_comb
    begin
        jsu_pkg::grp_t g;
        logic [4:0]    dig;
        logic [15:0]   hv_sh;
        logic [20:0]   pair_cp;
        logic          done;
        logic [1:0]    done_st;
        logic          esc;
        logic          txt;

        g              = '0;
        dig            = jsu_pkg::hex_digit(in_byte);
        hv_sh          = {hex_value_reg[11:0], dig[3:0]};
        pair_cp        = jsu_pkg::SUPP_BASE + {1'b0, high_half_reg[9:0], 10'd0}
                         + {5'd0, hv_sh} - jsu_pkg::LO_SURR_BASE;
        done           = 1'b0;
        done_st        = jsu_pkg::ST_OK;
        esc            = 1'b0;
        txt            = 1'b0;
        phase_next     = phase_reg;
        hex_count_next = hex_count_reg;
        hex_value_next = hex_value_reg;
        high_half_next = high_half_reg;

        if (mode)
        begin
            done = 1'b1;
            case (phase_reg)
                jsu_pkg::PH_HEX:     done_st = jsu_pkg::ST_BAD_UNI;
                jsu_pkg::PH_LOW_HEX: done_st = jsu_pkg::ST_BAD_PAIR;
                jsu_pkg::PH_AFTER_HI, jsu_pkg::PH_AFTER_HI_BS:
                begin
                    g       = jsu_pkg::grp_utf8(g, {5'd0, high_half_reg});
                    done_st = jsu_pkg::ST_UNTERM;
                end
                default:             done_st = jsu_pkg::ST_UNTERM;
            endcase
        end
        else
        begin
            case (phase_reg)
                jsu_pkg::PH_ESC: esc = 1'b1;
                jsu_pkg::PH_HEX, jsu_pkg::PH_LOW_HEX:
                begin
                    if (!dig[4])
                    begin
                        done    = 1'b1;
                        done_st = (phase_reg == jsu_pkg::PH_HEX) ?
                                  jsu_pkg::ST_BAD_UNI : jsu_pkg::ST_BAD_PAIR;
                    end
                    else if (hex_count_reg != 2'd3)
                    begin
                        hex_value_next = hv_sh;
                        hex_count_next = hex_count_reg + 2'd1;
                    end
                    else
                    begin
                        hex_count_next = 2'd0;
                        hex_value_next = 16'd0;
                        phase_next     = jsu_pkg::PH_TEXT;
                        if (phase_reg == jsu_pkg::PH_LOW_HEX)
                            g = jsu_pkg::grp_utf8(g, pair_cp);
                        else if (hv_sh >= jsu_pkg::HI_SURR_MIN &&
                                 hv_sh <= jsu_pkg::HI_SURR_MAX)
                        begin
                            high_half_next = hv_sh;
                            phase_next     = jsu_pkg::PH_AFTER_HI;
                        end
                        else
                            g = jsu_pkg::grp_utf8(g, {5'd0, hv_sh});
                    end
                end
                jsu_pkg::PH_AFTER_HI:
                begin
                    if (in_byte == jsu_pkg::CH_BSLASH)
                        phase_next = jsu_pkg::PH_AFTER_HI_BS;
                    else
                    begin
                        g   = jsu_pkg::grp_utf8(g, {5'd0, high_half_reg});
                        txt = 1'b1;
                    end
                end
                jsu_pkg::PH_AFTER_HI_BS:
                begin
                    if (in_byte == jsu_pkg::CH_U)
                    begin
                        phase_next     = jsu_pkg::PH_LOW_HEX;
                        hex_count_next = 2'd0;
                        hex_value_next = 16'd0;
                    end
                    else
                    begin
                        g   = jsu_pkg::grp_utf8(g, {5'd0, high_half_reg});
                        esc = 1'b1;
                    end
                end
                default: txt = 1'b1;
            endcase
        end

        if (txt)
        begin
            phase_next = jsu_pkg::PH_TEXT;
            if (in_byte == jsu_pkg::CH_QUOTE)
            begin
                done    = 1'b1;
                done_st = jsu_pkg::ST_OK;
            end
            else if (in_byte == jsu_pkg::CH_BSLASH)
                phase_next = jsu_pkg::PH_ESC;
            else
                g = jsu_pkg::grp_byte(g, in_byte);
        end

        if (esc)
        begin
            phase_next = jsu_pkg::PH_TEXT;
            case (in_byte)
                jsu_pkg::CH_B: g = jsu_pkg::grp_byte(g, 8'h08);
                jsu_pkg::CH_F: g = jsu_pkg::grp_byte(g, 8'h0C);
                jsu_pkg::CH_N: g = jsu_pkg::grp_byte(g, 8'h0A);
                jsu_pkg::CH_R: g = jsu_pkg::grp_byte(g, 8'h0D);
                jsu_pkg::CH_T: g = jsu_pkg::grp_byte(g, 8'h09);
                jsu_pkg::CH_U:
                begin
                    phase_next     = jsu_pkg::PH_HEX;
                    hex_count_next = 2'd0;
                    hex_value_next = 16'd0;
                end
                default:       g = jsu_pkg::grp_byte(g, in_byte);
            endcase
        end

        // end of string clears the scan state
        if (done)
        begin
            g              = jsu_pkg::grp_done(g, done_st);
            phase_next     = jsu_pkg::PH_TEXT;
            hex_count_next = 2'd0;
            hex_value_next = 16'd0;
            high_half_next = 16'd0;
        end

        grp = g;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= jsu_pkg::PH_TEXT;
            hex_count_reg <= 2'd0;
            hex_value_reg <= 16'd0;
            high_half_reg <= 16'd0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            hex_count_reg <= hex_count_next;
            hex_value_reg <= hex_value_next;
            high_half_reg <= high_half_next;
        end
    end

endmodule

@@ hw/rtl/jsu_emit.sv @@
// ----------------------------------------------------------------------------
// jsu_emit: result buffer
// Holds one group of up to four result items and hands them out one per
// handshake, taking the next group as the last item leaves.
// ----------------------------------------------------------------------------
module jsu_emit
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  jsu_pkg::grp_t  grp,
    output logic           can_load,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,   // out_byte
    output logic           m_tlast,   // done_res
    output logic [2:0]     m_tuser    // has_byte, status[1:0]
);

    jsu_pkg::res_t [jsu_pkg::GRP_DEPTH-1:0] res_reg, res_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop      = (cnt_reg != 3'd0) && m_tready;
    assign can_load = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && m_tready);

    always_comb
    begin
        res_next = res_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            res_next = grp.res;
            cnt_next = grp.n;
        end
        else if (pop)
        begin
            res_next = {jsu_pkg::res_t'('0), res_reg[jsu_pkg::GRP_DEPTH-1:1]};
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 3'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = res_reg[0].out_byte;
    assign m_tlast  = res_reg[0].done_res;
    assign m_tuser  = {res_reg[0].status, res_reg[0].has_byte};

endmodule

@@ hw/rtl/json_string_unescape_utf8.sv @@
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: JSON string body to UTF-8 decoder
// Input register, decoder with scan state and a result buffer.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries the string body one byte per item, starting after the opening
//   quote; s_tuser high marks an end-of-text item (s_tdata ignored).
//   m_* carries decoded bytes (m_tuser[0] high) and, on m_tlast, the end of a
//   string with its status in m_tuser[2:1]: ok, bad \u escape, bad surrogate
//   pair, unterminated. A new string starts after each end.
//   An accepted item passes the input register, then the result buffer.
//   Throughput: one item per cycle while each item gives at most one result.
//   An item giving n results (up to four, surrogate and \u output) holds the
//   result buffer until all n are taken; the input register keeps one more
//   item. Items that give no result (backslash, hex digits) skip the result
//   buffer. Reset clears the scan state and both registers; the decoder starts
//   in plain text. When m_tready is low the buffer holds its item and s_tready
//   drops once the input register holds an item with results.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tuser,   // mode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,   // done_res
    output logic [2:0] m_tuser    // has_byte, status[1:0]
);

    logic          in_valid_reg;
    logic          in_mode_reg;
    logic [7:0]    in_byte_reg;
    logic          advance;
    logic          can_load;
    jsu_pkg::grp_t grp;

    assign advance  = in_valid_reg && ((grp.n == 3'd0) || can_load);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    jsu_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .mode    (in_mode_reg),
        .in_byte (in_byte_reg),
        .advance (advance),
        .grp     (grp)
    );

    jsu_emit u_emit
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && (grp.n != 3'd0)),
        .grp      (grp),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata == 8'd0 && !m_tuser[0])
        else $error("end item carries a byte");

    a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser[0] && m_tuser[2:1] == jsu_pkg::ST_OK)
        else $error("byte item malformed");

    a_grp_size: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> grp.n <= 3'd4)
        else $error("result group overflow");

    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("pending item lost");

endmodule

@@ dv/json_string_unescape_utf8_test.sv @@
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_test: self-checking bench for the JSON unescaper
// Drives string bodies built from plain bytes, simple escapes, \u escapes and
// surrogate pairs, with truncation and noise, under random stalls on both
// streams. A scoreboard decodes every accepted item and compares each result
// item, field by field, with the oldest decoded expectation.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_test;

    localparam int WDOG_LIMIT = 4000;

    class unescape_scoreboard;
        jsu_pkg::res_t   decoded_q[$];
        jsu_pkg::phase_t phase;
        logic [1:0]      hex_cnt;
        logic [15:0]     hex_acc;
        logic [15:0]     hi_half;
        int              errors;

        function new();
            errors = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            phase   = jsu_pkg::PH_TEXT;
            hex_cnt = '0;
            hex_acc = '0;
            hi_half = '0;
        endfunction

        function void queue_item(jsu_pkg::res_t r);
            decoded_q = {decoded_q, r};
        endfunction

        function void add_byte(logic [7:0] b);
            jsu_pkg::res_t r;
            r = '0;
            r.out_byte = b;
            r.has_byte = 1'b1;
            queue_item(r);
        endfunction

        function void add_done(logic [1:0] st);
            jsu_pkg::res_t r;
            r = '0;
            r.done_res = 1'b1;
            r.status   = st;
            queue_item(r);
            clear_scan();
        endfunction

        // lead byte is cut to 8 bits for wrapped pairs
        function void add_code(logic [31:0] cp);
            logic [31:0] t;
            if (cp < 32'h80) begin
                add_byte(cp[7:0]);
            end
            else if (cp < 32'h800) begin
                t = 32'hC0 | (cp >> 6);
                add_byte(t[7:0]);
                add_byte(8'h80 | {2'b00, cp[5:0]});
            end
            else if (cp < 32'h10000) begin
                t = 32'hE0 | (cp >> 12);
                add_byte(t[7:0]);
                add_byte(8'h80 | {2'b00, cp[11:6]});
                add_byte(8'h80 | {2'b00, cp[5:0]});
            end
            else begin
                t = 32'hF0 | (cp >> 18);
                add_byte(t[7:0]);
                add_byte(8'h80 | {2'b00, cp[17:12]});
                add_byte(8'h80 | {2'b00, cp[11:6]});
                add_byte(8'h80 | {2'b00, cp[5:0]});
            end
        endfunction

        // 16 when not a hex digit
        function int nibble_of(logic [7:0] c);
            if (c >= "0" && c <= "9")
                return c - "0";
            if (c >= "a" && c <= "f")
                return c - "a" + 10;
            if (c >= "A" && c <= "F")
                return c - "A" + 10;
            return 16;
        endfunction

        function void text_char(logic [7:0] c);
            if (c == jsu_pkg::CH_QUOTE)
                add_done(jsu_pkg::ST_OK);
            else if (c == jsu_pkg::CH_BSLASH)
                phase = jsu_pkg::PH_ESC;
            else
                add_byte(c);
        endfunction

        function void escape_char(logic [7:0] e);
            phase = jsu_pkg::PH_TEXT;
            case (e)
                jsu_pkg::CH_B: add_byte(8'h08);
                jsu_pkg::CH_F: add_byte(8'h0C);
                jsu_pkg::CH_N: add_byte(8'h0A);
                jsu_pkg::CH_R: add_byte(8'h0D);
                jsu_pkg::CH_T: add_byte(8'h09);
                jsu_pkg::CH_U:
                begin
                    phase   = jsu_pkg::PH_HEX;
                    hex_cnt = '0;
                    hex_acc = '0;
                end
                default: add_byte(e);
            endcase
        endfunction

        function void decode_item(logic mode, logic [7:0] c);
            int          d;
            logic [31:0] cp;
            if (mode) begin
                case (phase)
                    jsu_pkg::PH_HEX:     add_done(jsu_pkg::ST_BAD_UNI);
                    jsu_pkg::PH_LOW_HEX: add_done(jsu_pkg::ST_BAD_PAIR);
                    jsu_pkg::PH_AFTER_HI, jsu_pkg::PH_AFTER_HI_BS:
                    begin
                        add_code({16'h0, hi_half});
                        add_done(jsu_pkg::ST_UNTERM);
                    end
                    default:             add_done(jsu_pkg::ST_UNTERM);
                endcase
                return;
            end
            case (phase)
                jsu_pkg::PH_ESC: escape_char(c);
                jsu_pkg::PH_HEX, jsu_pkg::PH_LOW_HEX:
                begin
                    d = nibble_of(c);
                    if (d > 15) begin
                        add_done(phase == jsu_pkg::PH_HEX ?
                                 jsu_pkg::ST_BAD_UNI : jsu_pkg::ST_BAD_PAIR);
                    end
                    else begin
                        hex_acc = {hex_acc[11:0], d[3:0]};
                        if (hex_cnt < 2'd3) begin
                            hex_cnt = hex_cnt + 2'd1;
                        end
                        else begin
                            hex_cnt = '0;
                            if (phase == jsu_pkg::PH_HEX) begin
                                if (hex_acc >= jsu_pkg::HI_SURR_MIN &&
                                    hex_acc <= jsu_pkg::HI_SURR_MAX) begin
                                    hi_half = hex_acc;
                                    phase   = jsu_pkg::PH_AFTER_HI;
                                end
                                else begin
                                    add_code({16'h0, hex_acc});
                                    phase = jsu_pkg::PH_TEXT;
                                end
                            end
                            else begin
                                cp = 32'h10000 + (({16'h0, hi_half} - 32'hD800) << 10)
                                     + ({16'h0, hex_acc} - 32'hDC00);
                                add_code(cp);
                                phase = jsu_pkg::PH_TEXT;
                            end
                            hex_acc = '0;
                        end
                    end
                end
                jsu_pkg::PH_AFTER_HI:
                begin
                    if (c == jsu_pkg::CH_BSLASH) begin
                        phase = jsu_pkg::PH_AFTER_HI_BS;
                    end
                    else begin
                        add_code({16'h0, hi_half});
                        phase = jsu_pkg::PH_TEXT;
                        text_char(c);
                    end
                end
                jsu_pkg::PH_AFTER_HI_BS:
                begin
                    if (c == jsu_pkg::CH_U) begin
                        phase   = jsu_pkg::PH_LOW_HEX;
                        hex_cnt = '0;
                        hex_acc = '0;
                    end
                    else begin
                        add_code({16'h0, hi_half});
                        escape_char(c);
                    end
                end
                default:
                begin
                    phase = jsu_pkg::PH_TEXT;
                    text_char(c);
                end
            endcase
        endfunction

        function void check_item(jsu_pkg::res_t got);
            jsu_pkg::res_t want;
            if (decoded_q.size() == 0) begin
                $error("unexpected result item: out_byte %0h has_byte %0b done_res %0b status %0d",
                       got.out_byte, got.has_byte, got.done_res, got.status);
                errors++;
                return;
            end
            want = decoded_q.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.has_byte !== want.has_byte) begin
                $error("has_byte: expected %0b, got %0b", want.has_byte, got.has_byte);
                errors++;
            end
            if (got.done_res !== want.done_res) begin
                $error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // in_byte
    logic       s_tuser  = 1'b0;    // mode
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // out_byte
    logic       m_tlast;            // done_res
    logic [2:0] m_tuser;            // has_byte, status[1:0]

    unescape_scoreboard sb = new();
    bit                 calm = 1'b0;
    logic [8:0]         plan_q[$];   // {mode, byte}
    int                 sent;

    json_string_unescape_utf8 dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic push_item(input logic mode, input logic [7:0] b);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.decode_item(mode, b);
        sent++;
    endtask

    task automatic send_plan();
        foreach (plan_q[i])
            push_item(plan_q[i][8], plan_q[i][7:0]);
        plan_q.delete();
    endtask

    function automatic void plan_add(logic [8:0] v);
        plan_q = {plan_q, v};
    endfunction

    function automatic void plan_text(string s);
        for (int i = 0; i < s.len(); i++)
            plan_add({1'b0, s[i]});
    endfunction

    function automatic void plan_end();
        plan_add({1'b1, 8'($urandom_range(0, 255))});
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10)
            return "0" + {4'h0, n};
        return ($urandom_range(0, 1) ? "a" : "A") + {4'h0, n} - 8'd10;
    endfunction

    function automatic void plan_hex(logic [15:0] v);
        plan_add({1'b0, jsu_pkg::CH_BSLASH});
        plan_add({1'b0, jsu_pkg::CH_U});
        for (int i = 3; i >= 0; i--)
            plan_add({1'b0, hex_char(v[i*4 +: 4])});
    endfunction

    function automatic void plan_escape();
        logic [7:0] letters [8] = '{jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N,
                                    jsu_pkg::CH_R, jsu_pkg::CH_T, jsu_pkg::CH_QUOTE,
                                    jsu_pkg::CH_BSLASH, "/"};
        logic [7:0] e;
        if ($urandom_range(0, 3) == 0) begin
            e = 8'($urandom_range(0, 255));
            if (e == jsu_pkg::CH_U)
                e = "/";
        end
        else begin
            e = letters[$urandom_range(0, 7)];
        end
        plan_add({1'b0, jsu_pkg::CH_BSLASH});
        plan_add({1'b0, e});
    endfunction

    function automatic logic [15:0] high_half_rand();
        return 16'($urandom_range(16'hD800, 16'hDBFF));
    endfunction

    function automatic void plan_piece();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                b = 8'($urandom_range(0, 255));
                if (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH)
                    b = 8'($urandom_range(0, 8'h21));
                plan_add({1'b0, b});
            end
            3: plan_escape();
            4, 5:
            begin
                case ($urandom_range(0, 3))
                    0: plan_hex(16'($urandom_range(0, 16'h7F)));
                    1: plan_hex(16'($urandom_range(16'h80, 16'h7FF)));
                    2: plan_hex(16'($urandom_range(16'h800, 16'hFFFF)));
                    default: plan_hex(high_half_rand());
                endcase
            end
            6, 7:
            begin
                plan_hex(high_half_rand());
                if ($urandom_range(0, 1))
                    plan_hex(16'($urandom_range(16'hDC00, 16'hDFFF)));
                else
                    plan_hex(16'($urandom_range(0, 16'hFFFF)));
            end
            8:
            begin
                plan_hex(high_half_rand());
                plan_escape();
            end
            default: plan_add({1'b0, 8'($urandom_range(8'h80, 8'hFF))});
        endcase
    endfunction

    function automatic void plan_string();
        int pieces;
        int sel;
        int keep;
        pieces = $urandom_range(1, 6);
        for (int i = 0; i < pieces; i++)
            plan_piece();
        sel = $urandom_range(0, 19);
        if (sel < 14) begin
            plan_add({1'b0, jsu_pkg::CH_QUOTE});
        end
        else begin
            keep = $urandom_range(0, plan_q.size());
            while (plan_q.size() > keep)
                void'(plan_q.pop_back());
            if (sel < 17) begin
                plan_end();
            end
            else begin
                plan_add({1'b0, 8'($urandom_range(0, 255))});
                plan_add({1'b0, jsu_pkg::CH_QUOTE});
            end
        end
    endfunction

    // result side: random stall bursts
    initial
    begin
        jsu_pkg::res_t got;
        int            stall;
        stall = 0;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) begin
                got.out_byte = m_tdata;
                got.has_byte = m_tuser[0];
                got.status   = m_tuser[2:1];
                got.done_res = m_tlast;
                sb.check_item(got);
            end
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // pair to 4 bytes, simple escape, lone high half before a quote
        plan_text("\\uD83D\\uDE00\\n\\uDBFF\"");
        // end of text inside hex digits, then extreme bytes left unterminated
        plan_text("\\u1");
        plan_end();
        plan_add({1'b0, 8'h00});
        plan_add({1'b0, 8'hFF});
        plan_end();
        send_plan();

        sent = 0;
        while (sent < 450) begin
            if (sent >= 390)
                calm = 1'b1;
            plan_string();
            send_plan();
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_decode.sv
hw/rtl/jsu_emit.sv
hw/rtl/json_string_unescape_utf8.sv
dv/json_string_unescape_utf8_test.sv
